@@ rtl/chtc_pkg.sv @@
// ----------------------------------------------------------------------------
// chtc_pkg: shared types and constants for the coalesced hash table
// Beat layouts, slot entry layout, sequencer states and op codes.
// ----------------------------------------------------------------------------
package chtc_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned DIV_W    = $clog2(HASH_W);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // kind zero is reserved: requests with it are ignored and never match
  localparam logic [3:0] KIND_NONE = 4'd0;

  localparam logic [1:0] CFG_SLOTS  = 2'd0;
  localparam logic [1:0] CFG_MODULO = 2'd1;

  typedef struct packed {
    logic [1:0]          op;
    logic [3:0]          kind;
    logic [63:0]         key_value;
    logic [HASH_W-1:0]   req_hash;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             no_room;
    logic [7:0]       slot_index;
    logic [CNT_W-1:0] entry_count;
    logic             overflow_seen;
  } out_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic [KEY_BITS-1:0] key;
    logic [7:0]          next;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOME,
    ST_RD,
    ST_CMP,
    ST_SCAN,
    ST_LINK,
    ST_RESP
  } state_e;

endpackage

@@ rtl/chtc_ram.sv @@
// ----------------------------------------------------------------------------
// chtc_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/coalesced_hash_table_cellar_unit.sv @@
// Latency: clear, ignored and no-table items load the result 1 cycle after accept;
// others take 32 modulo cycles, 1 home-slot cycle, 2 per chain entry compared,
// 1 per cellar slot scanned (one more when the cellar runs dry), 1 for the link
// write and 1 to load the result. Clear empties the table in one cycle.
// Throughput: one item at a time; in_ready_o is high only when idle, and a result
// stalled by out_ready_i holds the block. Reset: async, active low; table empty.
// ----------------------------------------------------------------------------
// coalesced_hash_table_cellar_unit
// Coalesced hash table with cellar: lookup, find-or-insert and clear.
// ----------------------------------------------------------------------------
module coalesced_hash_table_cellar_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  chtc_pkg::in_t           in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output chtc_pkg::out_t          out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [chtc_pkg::CNT_W-1:0] cfg_data_i
);
  import chtc_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    slots_q, modulo_q;
  logic [CNT_W-1:0]    fst_q, fst_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic                ovf_q, ovf_d;
  logic [SLOTS-1:0]    valid_q, valid_d;

  logic [1:0]          op_q;
  logic [3:0]          kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [HASH_W-1:0]   hash_q;
  logic [CNT_W-1:0]    n_q, m_q;
  logic [DIV_W-1:0]    div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [IDX_W-1:0]    cur_q, cur_d, prev_q, prev_d;
  logic [CNT_W-1:0]    steps_q, steps_d;
  entry_t              pent_q, pent_d;
  logic                hit_q, hit_d, ins_q, ins_d, nor_q, nor_d;
  logic [IDX_W-1:0]    rslot_q, rslot_d;
  logic                out_valid_q;
  out_t                out_q;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  entry_t              wdata, rent;
  logic [ENTRY_W-1:0]  rdata;

  logic                accept;
  logic [CNT_W-1:0]    n_in, m_in;
  logic [CNT_W:0]      div_t;
  logic [IDX_W-1:0]    home;
  logic [CNT_W-1:0]    fst_clamp, fst_m1;
  logic                load_out;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // effective slot and bucket counts from the registers
  always_comb begin
    n_in = (slots_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_q;
    m_in = (modulo_q < n_in) ? modulo_q : n_in;
    if (m_in == '0) begin
      m_in = n_in;
    end
  end

  assign div_t     = {rem_q, hash_q[div_cnt_q]};
  assign home      = rem_q[IDX_W-1:0];
  assign rent      = entry_t'(rdata);
  assign fst_clamp = (fst_q > n_q) ? n_q : fst_q;
  assign fst_m1    = fst_clamp - CNT_W'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= CNT_W'(256);
      modulo_q <= CNT_W'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOTS:  slots_q  <= cfg_data_i;
        CFG_MODULO: modulo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fst_q       <= CNT_W'(SLOTS);
      used_q      <= '0;
      ovf_q       <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fst_q   <= fst_d;
      used_q  <= used_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_data_i.op;
      kind_q <= in_data_i.kind;
      key_q  <= in_data_i.key_value[KEY_BITS-1:0];
      hash_q <= in_data_i.req_hash;
      n_q    <= n_in;
      m_q    <= m_in;
    end
    div_cnt_q <= div_cnt_d;
    rem_q     <= rem_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    steps_q   <= steps_d;
    pent_q    <= pent_d;
    hit_q     <= hit_d;
    ins_q     <= ins_d;
    nor_q     <= nor_d;
    rslot_q   <= rslot_d;
    if (load_out) begin
      out_q.hit           <= hit_q;
      out_q.inserted      <= ins_q;
      out_q.no_room       <= nor_q;
      out_q.slot_index    <= rslot_q;
      out_q.entry_count   <= used_q;
      out_q.overflow_seen <= ovf_q;
    end
  end

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    fst_d     = fst_q;
    used_d    = used_q;
    ovf_d     = ovf_q;
    valid_d   = valid_q;
    div_cnt_d = div_cnt_q;
    rem_d     = rem_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    steps_d   = steps_q;
    pent_d    = pent_q;
    hit_d     = hit_q;
    ins_d     = ins_q;
    nor_d     = nor_q;
    rslot_d   = rslot_q;
    load_out  = 1'b0;
    we        = 1'b0;
    waddr     = cur_q;
    wdata     = '{kind: kind_q, key: key_q, next: cur_q};
    raddr     = cur_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hit_d     = 1'b0;
          ins_d     = 1'b0;
          nor_d     = 1'b0;
          rslot_d   = '0;
          rem_d     = '0;
          div_cnt_d = DIV_W'(HASH_W - 1);
          if (in_data_i.op == OP_CLEAR) begin
            valid_d = '0;
            used_d  = '0;
            ovf_d   = 1'b0;
            fst_d   = n_in;
            state_d = ST_RESP;
          end else if (in_data_i.op == OP_UNUSED || in_data_i.kind == KIND_NONE) begin
            state_d = ST_RESP;
          end else if (n_in == '0) begin
            if (in_data_i.op == OP_INSERT) begin
              ovf_d = 1'b1;
              nor_d = 1'b1;
            end
            state_d = ST_RESP;
          end else begin
            state_d = ST_DIV;
          end
        end
      end

      // restoring division, one hash bit per cycle
      ST_DIV: begin
        if (div_t >= {1'b0, m_q}) begin
          rem_d = CNT_W'(div_t - {1'b0, m_q});
        end else begin
          rem_d = div_t[CNT_W-1:0];
        end
        div_cnt_d = div_cnt_q - DIV_W'(1);
        if (div_cnt_q == '0) begin
          state_d = ST_HOME;
        end
      end

      ST_HOME: begin
        cur_d   = home;
        prev_d  = home;
        steps_d = '0;
        if (valid_q[home]) begin
          state_d = ST_RD;
        end else if (op_q == OP_INSERT) begin
          we      = 1'b1;
          waddr   = home;
          wdata   = '{kind: kind_q, key: key_q, next: home};
          valid_d[home] = 1'b1;
          if (used_q != '1) begin
            used_d = used_q + CNT_W'(1);
          end
          ins_d   = 1'b1;
          rslot_d = home;
          state_d = ST_RESP;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_RD: begin
        state_d = ST_CMP;
      end

      // compare one chain entry and follow its link
      ST_CMP: begin
        prev_d = cur_q;
        pent_d = rent;
        if (rent.kind == kind_q && rent.key == key_q) begin
          hit_d   = 1'b1;
          rslot_d = cur_q;
          state_d = ST_RESP;
        end else if (rent.next == cur_q || {1'b0, rent.next} >= n_q ||
                     !valid_q[rent.next] || steps_q == n_q - CNT_W'(1)) begin
          // only an insert pulls a stale free pointer down
          if (op_q == OP_INSERT) begin
            state_d = ST_SCAN;
            fst_d   = fst_clamp;
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          cur_d   = rent.next;
          steps_d = steps_q + CNT_W'(1);
          state_d = ST_RD;
        end
      end

      // cellar scan downward from the free pointer
      ST_SCAN: begin
        if (fst_q == '0) begin
          ovf_d   = 1'b1;
          nor_d   = 1'b1;
          state_d = ST_RESP;
        end else begin
          fst_d = fst_m1;
          if (!valid_q[fst_m1[IDX_W-1:0]]) begin
            we      = 1'b1;
            waddr   = fst_m1[IDX_W-1:0];
            wdata   = '{kind: kind_q, key: key_q, next: fst_m1[IDX_W-1:0]};
            valid_d[fst_m1[IDX_W-1:0]] = 1'b1;
            if (used_q != '1) begin
              used_d = used_q + CNT_W'(1);
            end
            cur_d   = fst_m1[IDX_W-1:0];
            ins_d   = 1'b1;
            rslot_d = fst_m1[IDX_W-1:0];
            state_d = ST_LINK;
          end
        end
      end

      // append the new slot to the chain tail
      ST_LINK: begin
        we      = 1'b1;
        waddr   = prev_q;
        wdata   = '{kind: pent_q.kind, key: pent_q.key, next: cur_q};
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  chtc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

@@ rtl/chtc_checker.sv @@
// ----------------------------------------------------------------------------
// chtc_checker: port-level checks for the hash table unit
// Watches the beats on the top-level ports.
// ----------------------------------------------------------------------------
module chtc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input chtc_pkg::out_t out_data_o
);
  import chtc_pkg::*;

  // a stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second item while busy");

  // a result flags at most one of hit, insert and no room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.inserted) &&
                    !(out_data_o.no_room && (out_data_o.hit || out_data_o.inserted)))
    else $error("conflicting result flags");

  // occupancy never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= CNT_W'(SLOTS))
    else $error("entry count beyond table size");

endmodule

bind coalesced_hash_table_cellar_unit chtc_checker u_chtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ dv/coalesced_hash_table_cellar_unit_test.sv @@
// ----------------------------------------------------------------------------
// Coalesced hash table with cellar: block-level test
// Drives lookup, find-or-insert and clear beats against a behavioral table,
// compares every response field and sweeps slot and bucket settings.
// ----------------------------------------------------------------------------
module coalesced_hash_table_cellar_unit_test;
  import chtc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [CNT_W-1:0] cfg_data_i = '0;

  coalesced_hash_table_cellar_unit u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Behavioral copy of the table
  logic [3:0] tbl_kind [SLOTS];
  logic [63:0] tbl_key [SLOTS];
  logic [7:0] tbl_next [SLOTS];
  int unsigned scan_top, used_cnt;
  logic ovf_flag = 1'b0;
  int unsigned slots_reg, mod_reg;

  out_t pending_resp [$];
  int unsigned err_cnt;
  int unsigned resp_cnt;
  bit quiet_mode;      // no random idling
  bit hold_rx;         // long receiver hold-off
  int unsigned ins_cnt, hit_cnt, full_cnt;

  // Compute the expected response and update the table copy
  function automatic out_t table_apply(in_t b);
    out_t r;
    int unsigned n, m, home, cur, prev, steps;
    bit found, have_prev, got;
    r = '0;
    n = (slots_reg < SLOTS) ? slots_reg : SLOTS;
    found = 0;
    have_prev = 0;
    got = 0;
    if (b.op == OP_CLEAR) begin
      foreach (tbl_kind[i]) tbl_kind[i] = '0;
      used_cnt = 0;
      ovf_flag = 0;
      scan_top = n;
    end else if (b.op == OP_UNUSED || b.kind == 0) begin
    end else if (n == 0) begin
      if (b.op == OP_INSERT) begin
        ovf_flag = 1;
        r.no_room = 1;
      end
    end else begin
      m = (mod_reg < n) ? mod_reg : n;
      if (m == 0) m = n;
      home = b.req_hash % m;
      cur = home;
      prev = home;
      if (tbl_kind[home] != 0) begin
        have_prev = 1;
        for (steps = 0; steps < n; steps++) begin
          prev = cur;
          if (tbl_kind[cur] == b.kind && tbl_key[cur] == b.key_value) begin
            found = 1;
            break;
          end
          if (tbl_next[cur] == cur || tbl_next[cur] >= n || tbl_kind[tbl_next[cur]] == 0)
            break;
          cur = tbl_next[cur];
        end
      end
      if (found) begin
        r.hit = 1;
        r.slot_index = cur[7:0];
      end else if (b.op == OP_INSERT) begin
        if (have_prev) begin
          if (scan_top > n) scan_top = n;
          while (scan_top != 0) begin
            scan_top--;
            if (tbl_kind[scan_top] == 0) begin
              cur = scan_top;
              got = 1;
              break;
            end
          end
        end else begin
          got = 1;
        end
        if (!got) begin
          ovf_flag = 1;
          r.no_room = 1;
        end else begin
          tbl_kind[cur] = b.kind;
          tbl_key[cur] = b.key_value;
          tbl_next[cur] = cur[7:0];
          if (have_prev) tbl_next[prev] = cur[7:0];
          if (used_cnt < 511) used_cnt++;
          r.inserted = 1;
          r.slot_index = cur[7:0];
        end
      end
    end
    r.entry_count = used_cnt[8:0];
    r.overflow_seen = ovf_flag;
    return r;
  endfunction

  // Send one beat; predict on acceptance. Valid stays up after the
  // accept so that back-to-back beats need no second assignment.
  task automatic send_beat(logic [1:0] op, logic [3:0] kind, logic [63:0] key,
                           logic [31:0] hash);
    in_t b;
    b.op = op;
    b.kind = kind;
    b.key_value = key;
    b.req_hash = hash;
    while (!quiet_mode && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_resp.push_back(table_apply(b));
  endtask

  task automatic drain_table;
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
    drain_table();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SLOTS) slots_reg = val;
    else if (idx == CFG_MODULO) mod_reg = val;
  endtask

  // Receiver with random stalls
  always @(posedge clk_i) begin
    if (hold_rx) out_ready_i <= 1'b0;
    else out_ready_i <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // Response checker
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      resp_cnt++;
      if (pending_resp.size() == 0) begin
        $error("response with nothing expected");
        err_cnt++;
      end else begin
        e = pending_resp.pop_front();
        if (e.hit) hit_cnt++;
        if (e.inserted) ins_cnt++;
        if (e.no_room) full_cnt++;
        if (out_data_o.hit !== e.hit) begin
          $error("hit exp %0d got %0d", e.hit, out_data_o.hit); err_cnt++;
        end
        if (out_data_o.inserted !== e.inserted) begin
          $error("inserted exp %0d got %0d", e.inserted, out_data_o.inserted); err_cnt++;
        end
        if (out_data_o.no_room !== e.no_room) begin
          $error("no_room exp %0d got %0d", e.no_room, out_data_o.no_room); err_cnt++;
        end
        if (out_data_o.slot_index !== e.slot_index) begin
          $error("slot_index exp %0d got %0d", e.slot_index, out_data_o.slot_index);
          err_cnt++;
        end
        if (out_data_o.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_data_o.entry_count);
          err_cnt++;
        end
        if (out_data_o.overflow_seen !== e.overflow_seen) begin
          $error("overflow_seen exp %0d got %0d", e.overflow_seen,
                 out_data_o.overflow_seen);
          err_cnt++;
        end
      end
    end
  end

  // Key pool keeps hits and chain collisions frequent
  logic [63:0] key_pool [16];
  logic [3:0] kind_pool [16];

  task automatic random_beat(int unsigned nslots);
    int unsigned sel, p;
    logic [1:0] op;
    logic [63:0] key;
    logic [3:0] kind;
    sel = $urandom_range(99);
    p = $urandom_range(15);
    if (sel < 2) op = OP_CLEAR;
    else if (sel < 3) op = OP_UNUSED;
    else if (sel < 60) op = OP_INSERT;
    else op = OP_LOOKUP;
    if ($urandom_range(3) == 0) begin
      key = {$urandom, $urandom};
      kind = 4'($urandom_range(15));
    end else begin
      key = key_pool[p];
      kind = kind_pool[p];
    end
    if ($urandom_range(7) == 0) kind = KIND_NONE;
    send_beat(op, kind, key, $urandom_range(3) == 0 ? $urandom : $urandom_range(nslots + 3));
  endtask

  task automatic test_directed;
    send_beat(OP_LOOKUP, 4'd1, 64'd0, 32'd0);
    send_beat(OP_INSERT, 4'd1, 64'd0, 32'd0);
    send_beat(OP_INSERT, 4'd15, '1, '1);
    send_beat(OP_LOOKUP, 4'd15, '1, '1);
    send_beat(OP_INSERT, 4'd2, 64'd0, 32'd256);     // collides with slot 0
    send_beat(OP_INSERT, 4'd3, 64'h5555_5555_5555_5555, 32'd0);
    send_beat(OP_LOOKUP, 4'd3, 64'h5555_5555_5555_5555, 32'd512);
    send_beat(OP_LOOKUP, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
    send_beat(OP_INSERT, KIND_NONE, 64'd7, 32'd7);  // reserved kind
    send_beat(OP_UNUSED, 4'd1, 64'd0, 32'd0);
    send_beat(OP_CLEAR, 4'd0, 64'd0, 32'd0);
    send_beat(OP_LOOKUP, 4'd1, 64'd0, 32'd0);
    // tiny table: overflow, then clear
    write_reg(CFG_SLOTS, 9'd2);
    write_reg(CFG_MODULO, 9'd0);                    // zero modulo
    send_beat(OP_INSERT, 4'd1, 64'd1, 32'd1);
    send_beat(OP_INSERT, 4'd1, 64'd2, 32'd3);
    send_beat(OP_INSERT, 4'd1, 64'd3, 32'd5);
    send_beat(OP_LOOKUP, 4'd1, 64'd2, 32'd1);
    send_beat(OP_CLEAR, 4'd0, 64'd0, 32'd0);
    // no table
    write_reg(CFG_SLOTS, 9'd0);
    send_beat(OP_LOOKUP, 4'd1, 64'd1, 32'd1);
    send_beat(OP_INSERT, 4'd1, 64'd1, 32'd1);
    // stale free pointer after growing the table
    write_reg(CFG_SLOTS, 9'd511);
    write_reg(CFG_MODULO, 9'd511);
    send_beat(OP_INSERT, 4'd4, 64'd9, 32'd9);
    send_beat(OP_CLEAR, 4'd0, 64'd0, 32'd0);
    drain_table();
  endtask

  task automatic test_random_sweep;
    int unsigned ns [5] = '{256, 16, 1, 40, 256};
    int unsigned ms [5] = '{256, 3, 1, 300, 5};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SLOTS, ns[ph][8:0]);
      write_reg(CFG_MODULO, ms[ph][8:0]);
      send_beat(OP_CLEAR, 4'd0, 64'd0, 32'd0);
      quiet_mode = (ph == 3);
      for (int i = 0; i < 140; i++) random_beat(ns[ph] > 256 ? 256 : ns[ph]);
    end
    quiet_mode = 0;
  endtask

  // Receiver held off while inserts keep coming
  task automatic test_backpressure;
    fork
      begin
        hold_rx = 1;
        repeat (400) @(posedge clk_i);
        hold_rx = 0;
      end
      begin
        for (int i = 0; i < 60; i++) random_beat(256);
        in_valid_i <= 1'b0;
      end
    join
    drain_table();
  endtask

  initial begin
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      kind_pool[i] = 4'($urandom_range(15, 1));
    end
    foreach (tbl_kind[i]) tbl_kind[i] = '0;
    slots_reg = 256;
    mod_reg = 256;
    scan_top = 256;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_sweep();
    test_backpressure();
    drain_table();
    $display("Covered %0d responses: %0d inserts, %0d hits, %0d no-room results,",
             resp_cnt, ins_cnt, hit_cnt, full_cnt);
    $display("over several slot and bucket settings with a long receiver hold-off.");
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #400000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/chtc_pkg.sv
rtl/chtc_ram.sv
rtl/coalesced_hash_table_cellar_unit.sv
rtl/chtc_checker.sv
dv/coalesced_hash_table_cellar_unit_test.sv
